FILE: src/ipic_pkg.sv
package ipic_pkg;

    localparam int IVAL_W  = 16;
    localparam int SLOT_W  = 6;
    localparam int OP_W    = 2;
    localparam int PHASE_W = 2;
    localparam int PERIOD_W = 16;

    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_EDGE  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;
    localparam logic [OP_W-1:0] OP_REARM = 2'd3;

    localparam logic [PHASE_W-1:0] PH_IDLE    = 2'd0;
    localparam logic [PHASE_W-1:0] PH_READING = 2'd1;
    localparam logic [PHASE_W-1:0] PH_ENDED   = 2'd2;
    localparam logic [PHASE_W-1:0] PH_VALID   = 2'd3;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'hFFFF;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               stored;
        logic [SLOT_W-1:0]  slot;
        logic [IVAL_W-1:0]  interval;
        logic               overflowed;
        logic               rd_sel;
    } t_step_res;

endpackage

FILE: src/ir_pulse_interval_capture_unit.sv
// Infrared pulse interval capture. Each input beat carries an operation in
// s_axis_tuser (tick, capture edge, buffer read, rearm) and a buffer index
// in s_axis_tdata; every beat produces exactly one result beat that reports
// the capture phase after the step, whether an interval was stored, the
// slot touched, the interval value and whether an armed overflow was handled.
// One beat is taken per clock, back to back, whenever the result register is
// empty or being drained in the same cycle; the result appears in the cycle
// after acceptance, set by the single state update and the registered read
// port of the interval buffer. The user must write counter_period through
// i_cfg_we / i_cfg_wdata only while the unit is idle, not enforced by the unit;
// it resets to 65535. Buffer entries have no reset: read only slots that have
// been written at least once; stored intervals survive rearm and later frames.
module ir_pulse_interval_capture_unit #(
    parameter int BUFFER_DEPTH  = 64,
    parameter int COUNTER_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // counter period register
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    // input beats
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [5:0] read_index, [7:6] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] operation
    // result beats
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [1:0] phase, [2] stored, [8:3] slot,
                                        // [24:9] interval, [25] overflowed,
                                        // [31:26] zero
);
    import ipic_pkg::*;

    localparam int ADDR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    logic              accept;
    t_step_res         step_res;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [IVAL_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [IVAL_W-1:0] rd_data;
    logic [IVAL_W-1:0] out_interval;

    // result register; payload held while the sink stalls
    logic      r_out_valid;
    t_step_res r_res;

    // a new beat may enter when the result slot is empty or frees up this cycle
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    ipic_core #(
        .BUFFER_DEPTH  (BUFFER_DEPTH),
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_accept     (accept),
        .i_op         (s_axis_tuser),
        .i_read_index (s_axis_tdata[SLOT_W-1:0]),
        .o_res        (step_res),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr)
    );

    // read data is registered at the accept edge, alongside r_res, and only
    // changes on the next read beat, so it stays aligned with a stalled result
    ipic_buf #(
        .DEPTH (BUFFER_DEPTH)
    ) u_buf (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= step_res;
        end
    end

    // in-range reads take the buffer word, everything else the step's own value
    assign out_interval  = r_res.rd_sel ? rd_data : r_res.interval;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_res.overflowed, out_interval, r_res.slot,
                            r_res.stored, r_res.phase};

endmodule

FILE: src/ipic_buf.sv
module ipic_buf #(
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [ADDR_W-1:0]         i_wr_addr,
    input  logic [ipic_pkg::IVAL_W-1:0] i_wr_data,
    input  logic                      i_rd_en,
    input  logic [ADDR_W-1:0]         i_rd_addr,
    output logic [ipic_pkg::IVAL_W-1:0] o_rd_data
);
    import ipic_pkg::*;

    logic [IVAL_W-1:0] r_mem [DEPTH];
    logic [IVAL_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: src/ipic_core.sv
module ipic_core #(
    parameter int BUFFER_DEPTH = 64,
    parameter int COUNTER_WIDTH = 16,
    localparam int ADDR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ipic_pkg::PERIOD_W-1:0] i_cfg_wdata,
    input  logic                          i_accept,
    input  logic [ipic_pkg::OP_W-1:0]     i_op,
    input  logic [ipic_pkg::SLOT_W-1:0]   i_read_index,
    output ipic_pkg::t_step_res           o_res,
    output logic                          o_wr_en,
    output logic [ADDR_W-1:0]             o_wr_addr,
    output logic [ipic_pkg::IVAL_W-1:0]   o_wr_data,
    output logic                          o_rd_en,
    output logic [ADDR_W-1:0]             o_rd_addr
);
    import ipic_pkg::*;

    localparam int FILL_W  = $clog2(BUFFER_DEPTH + 1);
    localparam int CMP_W   = (COUNTER_WIDTH > PERIOD_W) ? COUNTER_WIDTH : PERIOD_W;
    localparam int SEXT_W  = (FILL_W > SLOT_W) ? FILL_W : SLOT_W;
    localparam int RIDX_W  = (ADDR_W > SLOT_W) ? ADDR_W : SLOT_W;
    localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = {COUNTER_WIDTH{1'b1}};

    logic [PERIOD_W-1:0]      r_period;
    logic [PHASE_W-1:0]       r_phase, n_phase;
    logic [FILL_W-1:0]        r_fill, n_fill;
    logic [COUNTER_WIDTH-1:0] r_cnt, n_cnt;
    logic                     r_arm, n_arm;

    logic [CMP_W-1:0]  cnt_ext;
    logic [SEXT_W-1:0] fill_ext;
    logic [RIDX_W-1:0] ridx_ext;
    logic              wrap;
    logic              in_range;
    t_step_res         res;

    assign cnt_ext  = CMP_W'(r_cnt);
    assign fill_ext = SEXT_W'(r_fill);
    assign ridx_ext = RIDX_W'(i_read_index);
    assign wrap     = (cnt_ext >= CMP_W'(r_period)) || (r_cnt == CNT_MAX);
    assign in_range = 32'(i_read_index) < 32'(BUFFER_DEPTH);

    always_comb begin
        n_phase = r_phase;
        n_fill  = r_fill;
        n_cnt   = r_cnt;
        n_arm   = r_arm;
        res     = '0;
        o_wr_en = 1'b0;
        o_rd_en = 1'b0;
        case (i_op)
            OP_TICK: begin
                if (wrap) begin
                    n_cnt = '0;
                    if (r_arm) begin
                        if (r_phase == PH_READING) begin
                            n_phase = PH_IDLE;
                            n_fill  = '0;
                        end else if (r_phase == PH_ENDED) begin
                            n_phase = PH_VALID;
                        end
                        n_arm          = 1'b0;
                        res.overflowed = 1'b1;
                    end
                end else begin
                    n_cnt = r_cnt + COUNTER_WIDTH'(1);
                end
            end
            OP_EDGE: begin
                if (r_phase == PH_IDLE) begin
                    n_cnt   = '0;
                    n_fill  = '0;
                    n_phase = PH_READING;
                end else if (r_phase == PH_READING) begin
                    if (r_fill < FILL_W'(BUFFER_DEPTH)) begin
                        o_wr_en      = i_accept;
                        res.stored   = 1'b1;
                        res.slot     = fill_ext[SLOT_W-1:0];
                        res.interval = cnt_ext[IVAL_W-1:0];
                        n_fill       = r_fill + FILL_W'(1);
                        n_cnt        = '0;
                    end else begin
                        n_phase = PH_ENDED;
                        n_fill  = '0;
                    end
                end
                n_arm = 1'b1;
            end
            OP_READ: begin
                o_rd_en    = i_accept;
                res.slot   = i_read_index;
                res.rd_sel = in_range;
            end
            OP_REARM: begin
                n_phase = PH_IDLE;
                n_fill  = '0;
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
        res.phase = n_phase;
    end

    assign o_res     = res;
    assign o_wr_addr = r_fill[ADDR_W-1:0];
    assign o_wr_data = cnt_ext[IVAL_W-1:0];
    assign o_rd_addr = ridx_ext[ADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
        end else if (i_cfg_we) begin
            r_period <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_fill  <= '0;
            r_cnt   <= '0;
            r_arm   <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_fill  <= n_fill;
            r_cnt   <= n_cnt;
            r_arm   <= n_arm;
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(BUFFER_DEPTH))
        else $error("fill index beyond buffer depth");

    a_edge_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && (i_op == OP_EDGE) |=> r_arm)
        else $error("edge did not arm overflow");

    a_rearm_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && (i_op == OP_REARM) |=> (r_phase == PH_IDLE) && (r_fill == '0))
        else $error("rearm did not return to idle");

    a_ovf_needs_arm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.overflowed |-> r_arm && wrap && (i_op == OP_TICK))
        else $error("overflow reported while disarmed");

endmodule
